// ----- rtl/core/accel_tilt_pitch_roll_top_assert.svh -----
// assertion macros for the port-level checker
`ifndef ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH

// property checked on every edge outside reset
`define TPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tpr checker: property failed");

// property checked on every edge, reset included
`define TPR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("tpr checker: property failed");

`endif

// ----- rtl/core/tpr_pkg.sv -----
// shared constants, types and the arctangent table of the tilt pipeline
package tpr_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int TABLE_LEN       = 24;
    localparam int TABLE_FRAC      = 24;
    localparam int NUM_STAGES      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int IN_W    = 16;
    localparam int OPP_W   = IN_W + 1;
    localparam int SQ_W    = 32;
    localparam int N_W     = 48;
    localparam int ROOT_W  = 24;
    localparam int REM_W   = 27;
    localparam int CW      = 27;
    localparam int ZW      = 34;
    localparam int OUT_W   = 15;
    localparam int RND_SH  = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] RND_BIAS = ZW'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [ZW-1:0] ANGLE_LIM = ZW'(64'sd90 <<< ANGLE_FRAC_BITS);

    // special-case flags that travel with each operand pair
    typedef struct packed {
        logic zero_opp;
        logic zero_mag;
        logic neg_opp;
    } tpr_flags_t;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

endpackage

// ----- rtl/core/tpr_sqrt_pipe.sv -----
// squares, sum and one-bit-per-stage integer square root of the magnitude
module tpr_sqrt_pipe (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               enable,
    input  logic                               in_valid,
    input  logic signed [tpr_pkg::IN_W-1:0]    a_in,
    input  logic signed [tpr_pkg::IN_W-1:0]    b_in,
    input  logic signed [tpr_pkg::OPP_W-1:0]   opp_in,
    output logic                               out_valid,
    output logic        [tpr_pkg::ROOT_W-1:0]  root_out,
    output logic signed [tpr_pkg::OPP_W-1:0]   opp_out,
    output tpr_pkg::tpr_flags_t                flags_out
);
    import tpr_pkg::*;

    logic [SQ_W-1:0]         sqa_reg, sqb_reg;
    logic signed [OPP_W-1:0] opp0_reg;
    logic                    v0_reg;
    logic [SQ_W-1:0]         sum_next;

    logic                    vld_reg  [ROOT_W+1];
    logic [REM_W-1:0]        rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]       root_reg [ROOT_W+1];
    logic [N_W-1:0]          n_reg    [ROOT_W+1];
    logic signed [OPP_W-1:0] opp_reg  [ROOT_W+1];
    tpr_flags_t              flg_reg  [ROOT_W+1];

    logic [REM_W-1:0]        rem_next  [ROOT_W];
    logic [ROOT_W-1:0]       root_next [ROOT_W];

    // squared components and their sum
    assign sum_next = sqa_reg + sqb_reg;

    // one root bit per stage: shift in two operand bits, try the subtract
    always_comb begin
        for (int i = 0; i < ROOT_W; i++) begin
            logic [REM_W-1:0] rem_w;
            logic [REM_W-1:0] trial;
            rem_w = {rem_reg[i][REM_W-3:0], n_reg[i][N_W-1 -: 2]};
            trial = REM_W'({root_reg[i], 2'b01});
            if (rem_w >= trial) begin
                rem_next[i]  = rem_w - trial;
                root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[i]  = rem_w;
                root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            for (int i = 0; i <= ROOT_W; i++) vld_reg[i] <= 1'b0;
        end else if (enable) begin
            v0_reg     <= in_valid;
            vld_reg[0] <= v0_reg;
            for (int i = 0; i < ROOT_W; i++) vld_reg[i+1] <= vld_reg[i];
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (enable) begin
            sqa_reg  <= SQ_W'(a_in) * SQ_W'(a_in);
            sqb_reg  <= SQ_W'(b_in) * SQ_W'(b_in);
            opp0_reg <= opp_in;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            n_reg[0]    <= {sum_next, 16'b0};
            opp_reg[0]  <= opp0_reg;
            flg_reg[0].zero_opp <= (opp0_reg == '0);
            flg_reg[0].zero_mag <= (sum_next == '0);
            flg_reg[0].neg_opp  <= opp0_reg[OPP_W-1];
            for (int i = 0; i < ROOT_W; i++) begin
                rem_reg[i+1]  <= rem_next[i];
                root_reg[i+1] <= root_next[i];
                n_reg[i+1]    <= {n_reg[i][N_W-3:0], 2'b00};
                opp_reg[i+1]  <= opp_reg[i];
                flg_reg[i+1]  <= flg_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root_out  = root_reg[ROOT_W];
    assign opp_out   = opp_reg[ROOT_W];
    assign flags_out = flg_reg[ROOT_W];
endmodule

// ----- rtl/core/tpr_cordic_pipe.sv -----
// vectoring cordic stages, rounding, clamp and special cases
module tpr_cordic_pipe (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               enable,
    input  logic                               in_valid,
    input  logic        [tpr_pkg::ROOT_W-1:0]  root_in,
    input  logic signed [tpr_pkg::OPP_W-1:0]   opp_in,
    input  tpr_pkg::tpr_flags_t                flags_in,
    output logic                               out_valid,
    output logic        [tpr_pkg::OUT_W-1:0]   angle_out
);
    import tpr_pkg::*;

    logic                    vld_reg [NUM_STAGES+1];
    logic signed [CW-1:0]    cx_reg  [NUM_STAGES+1];
    logic signed [CW-1:0]    cy_reg  [NUM_STAGES+1];
    logic signed [ZW-1:0]    z_reg   [NUM_STAGES+1];
    tpr_flags_t              flg_reg [NUM_STAGES+1];

    logic signed [CW-1:0]    cx_next [NUM_STAGES];
    logic signed [CW-1:0]    cy_next [NUM_STAGES];
    logic signed [ZW-1:0]    z_next  [NUM_STAGES];

    logic                    ov_reg;
    logic [OUT_W-1:0]        ang_reg;
    logic signed [ZW-1:0]    rnd;
    logic signed [ZW-1:0]    clamped;
    logic signed [ZW-1:0]    ang_next;

    // micro-rotations driving cy towards zero
    always_comb begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (!cy_reg[i][CW-1]) begin
                cx_next[i] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] - (cx_reg[i] >>> i);
                z_next[i]  = z_reg[i] + ATAN_TABLE[i];
            end else begin
                cx_next[i] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] + (cx_reg[i] >>> i);
                z_next[i]  = z_reg[i] - ATAN_TABLE[i];
            end
        end
    end

    // round to nearest, clamp, then the exact special cases
    always_comb begin
        rnd = (z_reg[NUM_STAGES] + RND_BIAS) >>> RND_SH;
        if (rnd > ANGLE_LIM)       clamped = ANGLE_LIM;
        else if (rnd < -ANGLE_LIM) clamped = -ANGLE_LIM;
        else                       clamped = rnd;
        if (flg_reg[NUM_STAGES].zero_opp)      ang_next = '0;
        else if (flg_reg[NUM_STAGES].zero_mag) begin
            ang_next = flg_reg[NUM_STAGES].neg_opp ? -ANGLE_LIM : ANGLE_LIM;
        end else                               ang_next = clamped;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            for (int i = 0; i <= NUM_STAGES; i++) vld_reg[i] <= 1'b0;
        end else if (enable) begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < NUM_STAGES; i++) vld_reg[i+1] <= vld_reg[i];
            ov_reg <= vld_reg[NUM_STAGES];
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (enable) begin
            cx_reg[0]  <= CW'({1'b0, root_in});
            cy_reg[0]  <= CW'(opp_in) <<< 8;
            z_reg[0]   <= '0;
            flg_reg[0] <= flags_in;
            for (int i = 0; i < NUM_STAGES; i++) begin
                cx_reg[i+1]  <= cx_next[i];
                cy_reg[i+1]  <= cy_next[i];
                z_reg[i+1]   <= z_next[i];
                flg_reg[i+1] <= flg_reg[i];
            end
            ang_reg <= ang_next[OUT_W-1:0];
        end
    end

    assign out_valid = ov_reg;
    assign angle_out = ang_reg;
endmodule

// ----- rtl/core/accel_tilt_pitch_roll_top.sv -----
// top level of the accelerometer pitch and roll pipeline
// Usage:
// One item on the s_ channel is a three-axis sample: tdata holds accel_x in
// bits 15:0, accel_y in 31:16 and accel_z in 47:32, all signed counts.
// One item on the m_ channel carries pitch_angle in bits 14:0 and roll_angle
// in bits 29:15, degrees times 2^ANGLE_FRAC_BITS, bits 31:30 zero.
// Every sample gives exactly one result item, in order.
// Throughput: one item per cycle while the receiver does not stall. The
// path is set by the 24-bit square root, one bit a stage, and the cordic,
// one micro-rotation a stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; s_tready stays high while no result waits or the
// result is being taken. Reset (aresetn low, synchronous) empties the
// pipeline; no result is lost or repeated across a stall.
module accel_tilt_pitch_roll_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pitch_angle, roll_angle, zero fill
);
    import tpr_pkg::*;

    logic                    enable;
    logic signed [IN_W-1:0]  ax, ay, az;
    logic signed [OPP_W-1:0] opp_p, opp_r;

    logic                    sp_v, sr_v, cp_v, cr_v;
    logic [ROOT_W-1:0]       sp_root, sr_root;
    logic signed [OPP_W-1:0] sp_opp, sr_opp;
    tpr_flags_t              sp_flg, sr_flg;
    logic [OUT_W-1:0]        pitch, roll;

    // the pipeline moves whenever the output stage is free or being read
    assign enable   = !m_tvalid || m_tready;
    assign s_tready = enable;

    assign ax    = s_tdata[15:0];
    assign ay    = s_tdata[31:16];
    assign az    = s_tdata[47:32];
    assign opp_p = -OPP_W'(ax);
    assign opp_r = OPP_W'(ay);

    // pitch: -x against the y-z magnitude
    tpr_sqrt_pipe u_sqrt_pitch (
        .aclk, .aresetn, .enable,
        .in_valid (s_tvalid && s_tready),
        .a_in (ay), .b_in (az), .opp_in (opp_p),
        .out_valid (sp_v), .root_out (sp_root), .opp_out (sp_opp), .flags_out (sp_flg)
    );

    tpr_cordic_pipe u_cordic_pitch (
        .aclk, .aresetn, .enable,
        .in_valid (sp_v), .root_in (sp_root), .opp_in (sp_opp), .flags_in (sp_flg),
        .out_valid (cp_v), .angle_out (pitch)
    );

    // roll: y against the x-z magnitude
    tpr_sqrt_pipe u_sqrt_roll (
        .aclk, .aresetn, .enable,
        .in_valid (s_tvalid && s_tready),
        .a_in (ax), .b_in (az), .opp_in (opp_r),
        .out_valid (sr_v), .root_out (sr_root), .opp_out (sr_opp), .flags_out (sr_flg)
    );

    tpr_cordic_pipe u_cordic_roll (
        .aclk, .aresetn, .enable,
        .in_valid (sr_v), .root_in (sr_root), .opp_in (sr_opp), .flags_in (sr_flg),
        .out_valid (cr_v), .angle_out (roll)
    );

    // both lanes run in lockstep
    assign m_tvalid = cp_v && cr_v;
    assign m_tdata  = {2'b00, roll, pitch};
endmodule

// ----- rtl/core/tpr_checker.sv -----
// port-level checker for the tilt pipeline and its bind
`include "accel_tilt_pitch_roll_top_assert.svh"

module tpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // a stalled result holds
    `TPR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // reset empties the pipeline
    `TPR_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid)
    // input is taken whenever no result waits
    `TPR_ASSERT(a_ready, !m_tvalid |-> s_tready)
    // angles stay within plus and minus ninety degrees
    `TPR_ASSERT(a_range, m_tvalid |->
        ($signed(m_tdata[14:0]) <= 15'sd11520) && ($signed(m_tdata[14:0]) >= -15'sd11520) &&
        ($signed(m_tdata[29:15]) <= 15'sd11520) && ($signed(m_tdata[29:15]) >= -15'sd11520))
endmodule

bind accel_tilt_pitch_roll_top tpr_checker u_tpr_checker (.*);

// ----- tb/sv/accel_tilt_pitch_roll_top_chk.sv -----
// checker for the tilt pipeline: predicts pitch and roll per sample and compares results
module accel_tilt_pitch_roll_top_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          n_errors,
    output int          n_pending
);
    import tpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_W-1:0] roll;
        logic [OUT_W-1:0] pitch;
    } tilt_t;

    tilt_t angles_due[$];

    // floor square root of a non-negative value, one bit pair at a time
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // atan2(opp, sqrt(sumsq)) in degrees scaled by 2^ANGLE_FRAC_BITS
    function automatic longint tilt_of(longint opp, longint unsigned sumsq);
        longint lim, cx, cy, acc, dx, dy, r;
        lim = longint'(90) <<< ANGLE_FRAC_BITS;
        acc = 0;
        if (opp == 0) return 0;
        if (sumsq == 0) return (opp > 0) ? lim : -lim;
        cx = longint'(floor_sqrt(sumsq << 16));
        cy = opp * 256;
        for (int i = 0; i < NUM_STAGES; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; acc += longint'(ATAN_TABLE[i]);
            end else begin
                cx -= dx; cy += dy; acc -= longint'(ATAN_TABLE[i]);
            end
        end
        r = (acc + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic tilt_t predict_tilt(logic [47:0] sample);
        longint ax, ay, az;
        longint p, q;
        tilt_t t;
        ax = longint'($signed(sample[15:0]));
        ay = longint'($signed(sample[31:16]));
        az = longint'($signed(sample[47:32]));
        p = tilt_of(-ax, ay * ay + az * az);
        q = tilt_of(ay, ax * ax + az * az);
        t.pitch = p[OUT_W-1:0];
        t.roll  = q[OUT_W-1:0];
        return t;
    endfunction

    assign n_pending = angles_due.size();

    // predict on each accepted sample, compare on each accepted result
    always @(posedge aclk) begin
        tilt_t got, want;
        int errs;
        if (!aresetn) begin
            n_errors <= 0;
            angles_due.delete();
        end else begin
            errs = n_errors;
            if (m_tvalid && m_tready) begin
                got = m_tdata[29:0];
                if (angles_due.size() == 0) begin
                    $error("result with no sample outstanding: %h", m_tdata);
                    errs++;
                end else begin
                    want = angles_due.pop_front();
                    if (got.pitch !== want.pitch) begin
                        $error("pitch_angle expected %h got %h", want.pitch, got.pitch);
                        errs++;
                    end
                    if (got.roll !== want.roll) begin
                        $error("roll_angle expected %h got %h", want.roll, got.roll);
                        errs++;
                    end
                    if (m_tdata[31:30] !== 2'b00) begin
                        $error("zero fill expected 0 got %b", m_tdata[31:30]);
                        errs++;
                    end
                end
            end
            n_errors <= errs;
            if (s_tvalid && s_tready)
                angles_due.push_back(predict_tilt(s_tdata));
        end
    end
endmodule

// ----- tb/sv/accel_tilt_pitch_roll_top_tb.sv -----
// testbench top: drives samples and result back-pressure, gives the verdict
module accel_tilt_pitch_roll_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 44;
    localparam int STALL_LIM = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          n_errors, n_pending;
    int          src_idle = 0, snk_idle = 0;
    bit          hold_sink = 1'b0;
    int          quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    accel_tilt_pitch_roll_top u_dut (.*);

    accel_tilt_pitch_roll_top_chk u_chk (.*);

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= !hold_sink && ($urandom_range(99) >= snk_idle);

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIM) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000 + 16'($urandom_range(3));
            1: return 16'h7FFF - 16'($urandom_range(3));
            2: return 16'($signed($urandom_range(64)) - 32);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one sample and hold it until taken, idling first at random
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] dir [12][3];
        dir = '{
            '{16'h0000, 16'h0000, 16'h0000}, '{16'h7FFF, 16'h0000, 16'h0000},
            '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h7FFF, 16'h0000},
            '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0000, 16'h7FFF},
            '{16'h0000, 16'h0000, 16'h8000}, '{16'h8000, 16'h8000, 16'h8000},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'h0001, 16'hFFFF, 16'h0001},
            '{16'hFFFF, 16'h0001, 16'h0000}, '{16'h5555, 16'hAAAA, 16'h00FF}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner samples: zero vector, single axes, full scale, small and mixed values
        foreach (dir[i]) send_sample(dir[i][0], dir[i][1], dir[i][2]);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 26 : (ph == 1) ? 50 : 0;
            snk_idle = (ph == 0) ? 50 : (ph == 1) ? 26 : 0;
            for (int n = 0; n < 446; n++)
                send_sample(rand_axis(), rand_axis(), rand_axis());
            // long receiver hold-off while the sender keeps offering
            if (ph == 2) begin
                hold_sink <= 1'b1;
                fork
                    begin
                        repeat (200) @(posedge aclk);
                        hold_sink <= 1'b0;
                    end
                    for (int n = 0; n < 100; n++)
                        send_sample(rand_axis(), rand_axis(), rand_axis());
                join
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge aclk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tpr_pkg.sv
rtl/core/tpr_sqrt_pipe.sv
rtl/core/tpr_cordic_pipe.sv
rtl/core/accel_tilt_pitch_roll_top.sv
rtl/core/tpr_checker.sv
tb/sv/accel_tilt_pitch_roll_top_chk.sv
tb/sv/accel_tilt_pitch_roll_top_tb.sv
